### src/wsbs_pkg.sv
package wsbs_pkg;

  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RES_ADDR_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO = 3'd0,
    REG_PAT_HI = 3'd1,
    REG_CARE   = 3'd2,
    REG_LEN    = 3'd3,
    REG_BASE   = 3'd4,
    REG_OFFSET = 3'd5
  } cfg_reg_e;

  // Settings every window cell needs to pick its own pattern byte.
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [PAT_BYTES-1:0]      care;
    logic [LEN_W-1:0]          len;
  } cell_cfg_t;

endpackage

### src/wsbs_ifs.sv
interface wsbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wsbs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

### src/wsbs_cell.sv
module wsbs_cell
  import wsbs_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  cell_cfg_t  cfg_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);

  logic [7:0] byte_q, byte_d;
  logic       active;
  logic [3:0] sel;

  // Cell IDX compares the byte that is IDX places behind the newest one, so it
  // lines up with pattern byte len-1-IDX.
  assign active = (LEN_W'(IDX) < cfg_i.len);
  assign sel    = 4'(cfg_i.len - LEN_W'(IDX) - LEN_W'(1));
  assign hit_o  = !active || !cfg_i.care[sel] || (byte_i == cfg_i.pattern[sel]);

  always_comb begin
    byte_d = byte_q;
    if (shift_i) begin
      byte_d = clear_i ? 8'd0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

### src/wildcard_byte_signature_scanner.sv
// Channel   Dir  Payload                         Handshake
// in_i      in   data_byte[7:0], last_byte       valid/ready
// out_o     out  found, match_address[31:0]      valid/ready
// cfg       in   cfg_index_i[2:0], cfg_wdata_i   cfg_we_i, no stall
//
// One byte is taken per cycle unless the input stalls; all window cells compare
// in parallel in the cycle a byte is taken, and the result sits in the output
// register in the cycle after. Throughput is set by that single output register:
// a new request is taken while a held result is being taken in the same cycle.
// Reset is asynchronous and clears the window, counters, pattern, base and offset.
// The input stalls only while a result is held and the output is not ready.
module wildcard_byte_signature_scanner
  import wsbs_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned ADDRESS_BITS      = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  wsbs_in_if.sink              in_i,
  wsbs_out_if.source           out_o
);

  localparam int unsigned AW = ADDRESS_BITS;
  localparam int unsigned NC = MAX_PATTERN_BYTES;

  logic [63:0]       pat_lo_q, pat_hi_q;
  logic [15:0]       care_q;
  logic [LEN_W-1:0]  plen_q;
  logic [31:0]       base_q;
  logic [31:0]       offset_q;
  logic [AW-1:0]     sum_q, sum_d;

  logic [31:0]       seen_q, seen_d, seen_nx;
  logic              reported_q, reported_d;
  logic              out_valid_q;
  logic              found_q;
  logic [31:0]       addr_q;

  logic [LEN_W-1:0]  eff_len;
  cell_cfg_t         cell_cfg;
  logic              accept;
  logic              last;
  logic              all_hit;
  logic              match;
  logic              emit;
  logic [31:0]       start;
  logic [AW-1:0]     match_addr;

  logic [NC-1:0][7:0] win;
  logic [NC-1:0]      hit;

  // Configuration registers. Base plus offset is kept as one sum so that a
  // match needs only one more add.
  always_comb begin
    sum_d = sum_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BASE:   sum_d = AW'(cfg_wdata_i[31:0]) + AW'(signed'(offset_q));
        REG_OFFSET: sum_d = AW'(base_q) + AW'(signed'(cfg_wdata_i[31:0]));
        default:    sum_d = sum_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= 16'hFFFF;
      plen_q   <= LEN_W'(1);
      base_q   <= '0;
      offset_q <= '0;
      sum_q    <= '0;
    end else begin
      sum_q <= sum_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_PAT_LO: pat_lo_q <= cfg_wdata_i;
          REG_PAT_HI: pat_hi_q <= cfg_wdata_i;
          REG_CARE:   care_q   <= cfg_wdata_i[15:0];
          REG_LEN:    plen_q   <= cfg_wdata_i[LEN_W-1:0];
          REG_BASE:   base_q   <= cfg_wdata_i[31:0];
          REG_OFFSET: offset_q <= cfg_wdata_i[31:0];
          default:    ;
        endcase
      end
    end
  end

  // A length of zero counts as one, and anything beyond the window is clamped.
  always_comb begin
    eff_len = plen_q;
    if (plen_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (plen_q > LEN_W'(NC)) begin
      eff_len = LEN_W'(NC);
    end
  end

  assign cell_cfg.pattern = {pat_hi_q, pat_lo_q};
  assign cell_cfg.care    = care_q;
  assign cell_cfg.len     = eff_len;

  assign accept   = in_i.valid && in_i.ready;
  assign last     = in_i.last_byte;
  assign in_i.ready = !out_valid_q || out_o.ready;

  for (genvar j = 0; j < NC; j++) begin : g_win
    logic [7:0] shift_in;
    if (j == 0) begin : g_head
      assign shift_in = in_i.data_byte;
    end else begin : g_link
      assign shift_in = win[j-1];
    end
    wsbs_cell #(.IDX(j)) u_wcell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .clear_i (last),
      .byte_i  (shift_in),
      .cfg_i   (cell_cfg),
      .byte_o  (win[j]),
      .hit_o   (hit[j])
    );
  end

  assign all_hit    = &hit;
  assign seen_nx    = seen_q + 32'd1;
  assign match      = !reported_q && (seen_nx >= 32'(eff_len)) && all_hit;
  assign emit       = accept && !reported_q && (match || last);
  assign start      = seen_nx - 32'(eff_len);
  assign match_addr = sum_q + AW'(start);

  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    if (accept) begin
      seen_d     = last ? 32'd0 : seen_nx;
      reported_d = last ? 1'b0 : (reported_q || match);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reported_q <= reported_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_q <= match;
      addr_q  <= match ? RES_ADDR_W'(match_addr) : 32'd0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.found         = found_q;
  assign out_o.match_address = addr_q;

  // A miss result only ever comes with the region's last byte.
  a_miss_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !match) |-> last)
    else $error("miss reported before the end of the region");

  // Once a match is reported the region stays silent.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && reported_q) |-> !emit)
    else $error("second result within one region");

  // A miss carries a zero address.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (addr_q == 32'd0))
    else $error("non-zero address on a miss");

  // The last byte rearms the scan.
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> ((seen_q == 32'd0) && !reported_q))
    else $error("scan not rearmed after the last byte");

endmodule
